[rtl/tfd_pkg.sv]
// ============================================================================
// tfd_pkg : shared types and constants of the telemetry frame deframer
// Tag characters, parser phase codes, result kinds and the result record.
// ============================================================================
package tfd_pkg;

    localparam int STAT_LEN = 21;
    localparam int POS_LEN  = 14;
    localparam int HDR_LEN  = 5;

    localparam logic [15:0] FOOTER_WORD = 16'hFFD9;

    localparam logic [7:0] CH_S   = 8'h73;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_I   = 8'h69;
    localparam logic [7:0] CH_M   = 8'h6D;
    localparam logic [7:0] CH_G   = 8'h67;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_TWO = 8'h32;

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_GOT_S = 4'd1;
    localparam logic [3:0] PH_GOT_T = 4'd2;
    localparam logic [3:0] PH_GOT_A = 4'd3;
    localparam logic [3:0] PH_GOT_I = 4'd4;
    localparam logic [3:0] PH_GOT_M = 4'd5;
    localparam logic [3:0] PH_GOT_G = 4'd6;
    localparam logic [3:0] PH_STAT  = 4'd7;
    localparam logic [3:0] PH_IMAGE = 4'd8;
    localparam logic [3:0] PH_POS   = 4'd9;

    localparam logic [1:0] KIND_STAT  = 2'd0;
    localparam logic [1:0] KIND_POS   = 2'd1;
    localparam logic [1:0] KIND_IMAGE = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    typedef logic [7:0] frame_arr_t [STAT_LEN];

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         status_flags;
        logic [31:0]        angle_bits;
        logic [31:0]        servo_bits;
        logic [31:0]        lat_bits;
        logic [31:0]        lng_bits;
        logic [31:0]        alt_bits;
        logic signed [15:0] map_index;
        logic [7:0]         data_byte;
        logic               image_done;
        logic               footer_ok;
    } result_t;

    function automatic logic [31:0] word_at(input frame_arr_t fb, input logic [4:0] pos);
        word_at = {fb[pos + 5'd3], fb[pos + 5'd2], fb[pos + 5'd1], fb[pos]};
    endfunction

endpackage

[rtl/tfd_parser.sv]
// ============================================================================
// tfd_parser : tag hunt, frame capture and image block tracking
// Holds the parser state and turns one byte into at most one result.
// ============================================================================
module tfd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output tfd_pkg::result_t  res
);

    logic [3:0]  phase_reg,  phase_next;
    logic [8:0]  count_reg,  count_next;
    logic [7:0]  len_reg,    len_next;
    logic [15:0] total_reg,  total_next;
    logic [15:0] seq_reg,    seq_next;
    logic [15:0] icount_reg, icount_next;
    logic        acc_reg,    acc_next;
    logic [15:0] last2_reg,  last2_next;

    tfd_pkg::frame_arr_t fb_reg;
    tfd_pkg::frame_arr_t fb_cur;
    logic                fb_we;
    logic [4:0]          fb_idx;
    logic [8:0]          count_inc;
    logic [9:0]          got;
    logic                payload;
    logic                footer_good;

    assign fb_idx    = count_reg[4:0];
    assign count_inc = count_reg + 9'd1;
    assign got       = {1'b0, count_reg} + 10'd1;

    always_comb
    begin
        for (int i = 0; i < tfd_pkg::STAT_LEN; i++)
        begin
            fb_cur[i] = (fb_we && fb_idx == 5'(i)) ? rx_byte : fb_reg[i];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        total_next  = total_reg;
        seq_next    = seq_reg;
        icount_next = icount_reg;
        acc_next    = acc_reg;
        last2_next  = last2_reg;
        fb_we       = 1'b0;
        payload     = 1'b0;
        footer_good = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        unique case (phase_reg)
            tfd_pkg::PH_GOT_S:
            begin
                phase_next = (rx_byte == tfd_pkg::CH_T) ? tfd_pkg::PH_GOT_T : tfd_pkg::PH_HUNT;
            end
            tfd_pkg::PH_GOT_T:
            begin
                phase_next = (rx_byte == tfd_pkg::CH_A) ? tfd_pkg::PH_GOT_A : tfd_pkg::PH_HUNT;
            end
            tfd_pkg::PH_GOT_A:
            begin
                phase_next = (rx_byte == tfd_pkg::CH_T) ? tfd_pkg::PH_STAT : tfd_pkg::PH_HUNT;
                count_next = '0;
            end
            tfd_pkg::PH_GOT_I:
            begin
                phase_next = (rx_byte == tfd_pkg::CH_M) ? tfd_pkg::PH_GOT_M : tfd_pkg::PH_HUNT;
            end
            tfd_pkg::PH_GOT_M:
            begin
                phase_next = (rx_byte == tfd_pkg::CH_G) ? tfd_pkg::PH_GOT_G : tfd_pkg::PH_HUNT;
            end
            tfd_pkg::PH_GOT_G:
            begin
                if (rx_byte == tfd_pkg::CH_ONE)
                begin
                    phase_next = tfd_pkg::PH_IMAGE;
                end
                else if (rx_byte == tfd_pkg::CH_TWO)
                begin
                    phase_next = tfd_pkg::PH_POS;
                end
                else
                begin
                    phase_next = tfd_pkg::PH_HUNT;
                end
                count_next = '0;
                acc_next   = 1'b0;
                len_next   = '0;
            end
            tfd_pkg::PH_STAT:
            begin
                fb_we      = count_reg < 9'(tfd_pkg::STAT_LEN);
                count_next = count_inc;
                if (count_inc >= 9'(tfd_pkg::STAT_LEN))
                begin
                    phase_next       = tfd_pkg::PH_HUNT;
                    count_next       = '0;
                    res_valid        = 1'b1;
                    res.kind         = tfd_pkg::KIND_STAT;
                    res.status_flags = fb_cur[0];
                    res.angle_bits   = tfd_pkg::word_at(fb_cur, 5'd1);
                    res.servo_bits   = tfd_pkg::word_at(fb_cur, 5'd5);
                    res.lat_bits     = tfd_pkg::word_at(fb_cur, 5'd9);
                    res.lng_bits     = tfd_pkg::word_at(fb_cur, 5'd13);
                    res.alt_bits     = tfd_pkg::word_at(fb_cur, 5'd17);
                end
            end
            tfd_pkg::PH_POS:
            begin
                fb_we      = count_reg < 9'(tfd_pkg::POS_LEN);
                count_next = count_inc;
                if (count_inc >= 9'(tfd_pkg::POS_LEN))
                begin
                    phase_next    = tfd_pkg::PH_HUNT;
                    count_next    = '0;
                    res_valid     = 1'b1;
                    res.kind      = tfd_pkg::KIND_POS;
                    res.lat_bits  = tfd_pkg::word_at(fb_cur, 5'd2);
                    res.lng_bits  = tfd_pkg::word_at(fb_cur, 5'd6);
                    res.alt_bits  = tfd_pkg::word_at(fb_cur, 5'd10);
                    res.map_index = {fb_cur[1], fb_cur[0]};
                end
            end
            tfd_pkg::PH_IMAGE:
            begin
                fb_we = count_reg < 9'(tfd_pkg::HDR_LEN);
                if (count_reg == 9'd1)
                begin
                    acc_next = {rx_byte, fb_reg[0]} == seq_reg;
                end
                else if (count_reg == 9'd3)
                begin
                    total_next = {rx_byte, fb_reg[2]};
                end
                else if (count_reg == 9'd4)
                begin
                    len_next = rx_byte;
                end
                else if (count_reg >= 9'(tfd_pkg::HDR_LEN) && acc_reg)
                begin
                    payload     = 1'b1;
                    icount_next = (icount_reg != 16'hFFFF) ? icount_reg + 16'd1 : icount_reg;
                    last2_next  = {last2_reg[7:0], rx_byte};
                end
                count_next = (count_reg != 9'h1FF) ? count_inc : count_reg;

                if (got >= 10'(tfd_pkg::HDR_LEN)
                    && got >= {2'b00, len_next} + 10'(tfd_pkg::HDR_LEN))
                begin
                    phase_next = tfd_pkg::PH_HUNT;
                    count_next = '0;
                    if (!acc_reg)
                    begin
                        seq_next    = '0;
                        icount_next = '0;
                        last2_next  = '0;
                        res_valid   = 1'b1;
                        res.kind    = tfd_pkg::KIND_ABORT;
                    end
                    else
                    begin
                        seq_next = seq_reg + 16'd1;
                        if (icount_next >= total_next)
                        begin
                            footer_good    = icount_next >= 16'd2
                                             && last2_next == tfd_pkg::FOOTER_WORD;
                            seq_next       = '0;
                            icount_next    = '0;
                            last2_next     = '0;
                            res_valid      = 1'b1;
                            res.kind       = tfd_pkg::KIND_IMAGE;
                            res.data_byte  = payload ? rx_byte : 8'd0;
                            res.image_done = 1'b1;
                            res.footer_ok  = footer_good;
                        end
                    end
                end
                if (!res_valid && payload)
                begin
                    res_valid     = 1'b1;
                    res.kind      = tfd_pkg::KIND_IMAGE;
                    res.data_byte = rx_byte;
                end
            end
            default:
            begin
                count_next = '0;
                if (rx_byte == tfd_pkg::CH_S)
                begin
                    phase_next = tfd_pkg::PH_GOT_S;
                end
                else if (rx_byte == tfd_pkg::CH_I)
                begin
                    phase_next = tfd_pkg::PH_GOT_I;
                end
                else
                begin
                    phase_next = tfd_pkg::PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= tfd_pkg::PH_HUNT;
            count_reg  <= '0;
            len_reg    <= '0;
            total_reg  <= '0;
            seq_reg    <= '0;
            icount_reg <= '0;
            acc_reg    <= 1'b0;
            last2_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            total_reg  <= total_next;
            seq_reg    <= seq_next;
            icount_reg <= icount_next;
            acc_reg    <= acc_next;
            last2_reg  <= last2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && fb_we)
        begin
            fb_reg[fb_idx] <= rx_byte;
        end
    end

endmodule

[rtl/telemetry_frame_deframer.sv]
// ============================================================================
// telemetry_frame_deframer : serial telemetry deframer, top level
// Input byte register, parser and result register with valid/stall channels.
// ============================================================================
// One received byte is taken per clock cycle for as long as the result side
// keeps up; a byte goes through the input register and its result (if any)
// through the result register. The parser state register, which a byte
// updates as the parser takes it, sets the rate. The input stalls only while
// a byte waits in the input register and the full result register is stalled.
module telemetry_frame_deframer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         status_flags,
    output logic [31:0]        angle_bits,
    output logic [31:0]        servo_bits,
    output logic [31:0]        lat_bits,
    output logic [31:0]        lng_bits,
    output logic [31:0]        alt_bits,
    output logic signed [15:0] map_index,
    output logic [7:0]         data_byte,
    output logic               image_done,
    output logic               footer_ok
);

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg;
    tfd_pkg::result_t out_res_reg;
    logic             advance;
    logic             fire;
    logic             res_valid;
    tfd_pkg::result_t res;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    tfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (s1_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold the byte until the parser takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign status_flags = out_res_reg.status_flags;
    assign angle_bits   = out_res_reg.angle_bits;
    assign servo_bits   = out_res_reg.servo_bits;
    assign lat_bits     = out_res_reg.lat_bits;
    assign lng_bits     = out_res_reg.lng_bits;
    assign alt_bits     = out_res_reg.alt_bits;
    assign map_index    = out_res_reg.map_index;
    assign data_byte    = out_res_reg.data_byte;
    assign image_done   = out_res_reg.image_done;
    assign footer_ok    = out_res_reg.footer_ok;

    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with no byte held");

    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while result register empty");

    a_done_is_image: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.image_done |-> out_res_reg.kind == tfd_pkg::KIND_IMAGE)
        else $error("image completion on a non-image result");

    a_footer_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.footer_ok |-> out_res_reg.image_done)
        else $error("footer flag without image completion");

    a_stat_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.kind != tfd_pkg::KIND_STAT
        |-> out_res_reg.status_flags == 8'd0 && out_res_reg.angle_bits == 32'd0)
        else $error("status fields set on a non-status result");

endmodule
